/* design/bsws_pkg.sv */
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared types and constants for the bounded stack with swap.
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int               OP_W        = 2;
    localparam int               LIMIT_W     = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SWAP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SWAP_RD2,
        ST_SWAP_WR1,
        ST_SWAP_WR2
    } t_state;

    typedef struct packed {
        logic               overflow;
        logic [LIMIT_W-1:0] fill_count;
    } t_res_stat;

endpackage

/* design/bsws_if.sv */
// ----------------------------------------------------------------------------
// bsws_if
// Valid/ready channel interfaces for stack operations and results.
// ----------------------------------------------------------------------------
interface bsws_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                     valid;
    logic                     ready;
    logic [bsws_pkg::OP_W-1:0] op;
    logic [DATA_WIDTH-1:0]    push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bsws_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [DATA_WIDTH-1:0]        pop_value;
    logic                         overflow;
    logic [bsws_pkg::LIMIT_W-1:0] fill_count;

    modport source (output valid, output pop_value, output overflow, output fill_count,
                    input ready);
    modport sink   (input valid, input pop_value, input overflow, input fill_count,
                    output ready);
endinterface

/* design/bounded_stack_with_swap.sv */
// ----------------------------------------------------------------------------
// bounded_stack_with_swap
// Bounded LIFO of data words with push, pop and swap of the top two words.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    op, push_value
//   o_out    out  valid/ready    pop_value, overflow, fill_count
//   i_cfg    in   i_cfg_we       i_cfg_wdata (depth_limit)
//
// push, refused push, empty pop, short swap and no-op give their result in the
// cycle they are accepted; pop then passes ST_POP_RD and swap passes ST_SWAP_RD2,
// ST_SWAP_WR1 and ST_SWAP_WR2, set by the single read and write port of the word
// store and its registered read data; reset clears the fill count and sets
// depth_limit to 256; the store is not cleared
// a two-entry result buffer lets one result wait while the next beat is taken
// ----------------------------------------------------------------------------
module bounded_stack_with_swap #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bsws_pkg::LIMIT_W-1:0] i_cfg_wdata,
    bsws_in_if.sink                      i_in,
    bsws_out_if.source                   o_out
);
    import bsws_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic                  res_valid;
    logic                  res_ready;
    logic [DATA_WIDTH-1:0] res_pop_value;
    t_res_stat             res_stat;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    bsws_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in            (i_in),
        .o_res_valid     (res_valid),
        .o_res_pop_value (res_pop_value),
        .o_res_stat      (res_stat),
        .i_res_ready     (res_ready),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    bsws_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsws_obuf #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_obuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (res_valid),
        .i_res_pop_value (res_pop_value),
        .i_res_stat      (res_stat),
        .o_res_ready     (res_ready),
        .o_out           (o_out)
    );

endmodule

/* design/bsws_mem.sv */
// ----------------------------------------------------------------------------
// bsws_mem
// Stack word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsws_mem #(
    parameter int   DEPTH      = 256,
    parameter int   DATA_WIDTH = 32,
    localparam int  ADDR_W     = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bsws_ctrl.sv */
// ----------------------------------------------------------------------------
// bsws_ctrl
// Operation sequencer: fill count, depth limit and read-modify-write of the
// stack store.
// ----------------------------------------------------------------------------
module bsws_ctrl #(
    parameter int   DEPTH      = 256,
    parameter int   DATA_WIDTH = 32,
    localparam int  ADDR_W     = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsws_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    bsws_in_if.sink                         i_in,
    output logic                            o_res_valid,
    output logic [DATA_WIDTH-1:0]           o_res_pop_value,
    output bsws_pkg::t_res_stat             o_res_stat,
    input  logic                            i_res_ready,
    output logic                            o_mem_we,
    output logic [ADDR_W-1:0]               o_mem_waddr,
    output logic [DATA_WIDTH-1:0]           o_mem_wdata,
    output logic                            o_mem_re,
    output logic [ADDR_W-1:0]               o_mem_raddr,
    input  logic [DATA_WIDTH-1:0]           i_mem_rdata
);
    import bsws_pkg::*;

    t_state               r_state, n_state;
    logic [LIMIT_W-1:0]   r_count, n_count;
    logic [LIMIT_W-1:0]   r_limit;
    logic [DATA_WIDTH-1:0] r_top, n_top;
    logic                 accept;
    logic                 full;
    logic [LIMIT_W-1:0]   cnt_m1;
    logic [LIMIT_W-1:0]   cnt_m2;

    assign accept = i_in.valid && i_in.ready;
    assign full   = (r_count >= r_limit) || (32'(r_count) >= 32'(DEPTH));
    assign cnt_m1 = r_count - LIMIT_W'(1);
    assign cnt_m2 = r_count - LIMIT_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_top           = r_top;
        i_in.ready      = 1'b0;
        o_res_valid     = 1'b0;
        o_res_pop_value = '0;
        o_res_stat      = '{overflow: 1'b0, fill_count: r_count};
        o_mem_we        = 1'b0;
        o_mem_waddr     = ADDR_W'(r_count);
        o_mem_wdata     = i_in.push_value;
        o_mem_re        = 1'b0;
        o_mem_raddr     = ADDR_W'(cnt_m1);

        case (r_state)
            ST_IDLE: begin
                i_in.ready = i_res_ready;
                if (accept) begin
                    case (t_op'(i_in.op))
                        OP_PUSH: begin
                            o_res_valid = 1'b1;
                            if (full) begin
                                o_res_stat.overflow = 1'b1;
                            end else begin
                                o_mem_we                = 1'b1;
                                n_count                 = r_count + LIMIT_W'(1);
                                o_res_stat.fill_count   = n_count;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                o_res_valid = 1'b1;
                            end else begin
                                o_mem_re = 1'b1;
                                n_count  = cnt_m1;
                                n_state  = ST_POP_RD;
                            end
                        end
                        OP_SWAP: begin
                            if (r_count < LIMIT_W'(2)) begin
                                o_res_valid = 1'b1;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = ST_SWAP_RD2;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                o_res_valid     = 1'b1;
                o_res_pop_value = i_mem_rdata;
                n_state         = ST_IDLE;
            end
            ST_SWAP_RD2: begin
                n_top       = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = ADDR_W'(cnt_m2);
                n_state     = ST_SWAP_WR1;
            end
            ST_SWAP_WR1: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = ADDR_W'(cnt_m1);
                o_mem_wdata = i_mem_rdata;
                n_state     = ST_SWAP_WR2;
            end
            ST_SWAP_WR2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = ADDR_W'(cnt_m2);
                o_mem_wdata = r_top;
                o_res_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/bsws_obuf.sv */
// ----------------------------------------------------------------------------
// bsws_obuf
// Two-entry result buffer between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module bsws_obuf #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_res_valid,
    input  logic [DATA_WIDTH-1:0] i_res_pop_value,
    input  bsws_pkg::t_res_stat   i_res_stat,
    output logic                  o_res_ready,
    bsws_out_if.source            o_out
);
    import bsws_pkg::*;

    logic                  r_v0, r_v1;
    logic [DATA_WIDTH-1:0] r_val0, r_val1;
    t_res_stat             r_stat0, r_stat1;
    logic                  pop;

    assign pop         = r_v0 && o_out.ready;
    assign o_res_ready = !r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (pop) begin
            r_v0 <= r_v1 || i_res_valid;
            r_v1 <= r_v1 && i_res_valid;
        end else if (i_res_valid) begin
            r_v0 <= 1'b1;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_v1) begin
                r_val0  <= r_val1;
                r_stat0 <= r_stat1;
                r_val1  <= i_res_pop_value;
                r_stat1 <= i_res_stat;
            end else begin
                r_val0  <= i_res_pop_value;
                r_stat0 <= i_res_stat;
            end
        end else if (i_res_valid) begin
            if (!r_v0) begin
                r_val0  <= i_res_pop_value;
                r_stat0 <= i_res_stat;
            end else begin
                r_val1  <= i_res_pop_value;
                r_stat1 <= i_res_stat;
            end
        end
    end

    assign o_out.valid      = r_v0;
    assign o_out.pop_value  = r_val0;
    assign o_out.overflow   = r_stat0.overflow;
    assign o_out.fill_count = r_stat0.fill_count;

endmodule

/* verif/bounded_stack_with_swap_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_stack_with_swap_test
// Drives push, pop, swap and no-op beats into the stack with random gaps
// and output stalls. A shadow stack in the bench predicts every result that
// the directed table does not give, and each result beat is compared field
// by field in arrival order. The directed table covers empty and full cases and
// extreme words. Random phases then run under several depth limits, including
// zero, one and a value above the store size.
// ----------------------------------------------------------------------------
module bounded_stack_with_swap_test;

    import bsws_pkg::*;

    localparam int              DATA_W      = 32;
    localparam int              DEPTH       = 256;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              TAIL_CYCLES = 8;
    localparam int              NUM_PHASES  = 10;
    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  pop_value;
        logic               overflow;
        logic [LIMIT_W-1:0] fill_count;
    } t_stack_result;

    typedef struct {
        bit                is_cfg;
        bit                typed;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] word;
        t_stack_result     want;
    } t_stim_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    bsws_in_if  #(.DATA_WIDTH(DATA_W)) op_bus ();
    bsws_out_if #(.DATA_WIDTH(DATA_W)) res_bus ();

    bounded_stack_with_swap #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (op_bus),
        .o_out       (res_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow stack
    logic [DATA_W-1:0]  shadow_words [DEPTH];
    int unsigned        shadow_fill  = 0;
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

    t_stack_result      pending_results [$];
    t_stim_row          directed_rows [$];
    bit                 cur_typed;
    t_stack_result      cur_want;
    int                 mismatches  = 0;
    int                 cycle_count = 0;
    int                 send_burst  = 0;
    int                 recv_burst  = 0;

    int phase_limit [NUM_PHASES] = '{256, 511, 40, 1, 2, 3, 0, 7, -1, 256};
    int phase_push  [NUM_PHASES] = '{80, 70, 15, 45, 45, 50, 50, 50, 50, 20};
    int phase_beats [NUM_PHASES] = '{450, 150, 400, 120, 120, 120, 60, 120, 150, 170};

    function automatic t_stack_result apply_stack_op(logic [OP_W-1:0] op,
                                                     logic [DATA_W-1:0] word);
        t_stack_result     res;
        int unsigned       room;
        logic [DATA_W-1:0] top;
        res  = '0;
        room = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
        case (op)
            OP_PUSH: begin
                if (shadow_fill >= room) begin
                    res.overflow = 1'b1;
                end else begin
                    shadow_words[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            OP_POP: begin
                if (shadow_fill > 0) begin
                    shadow_fill--;
                    res.pop_value = shadow_words[shadow_fill];
                end
            end
            OP_SWAP: begin
                if (shadow_fill >= 2) begin
                    top                         = shadow_words[shadow_fill - 1];
                    shadow_words[shadow_fill - 1] = shadow_words[shadow_fill - 2];
                    shadow_words[shadow_fill - 2] = top;
                end
            end
            default: ;
        endcase
        res.fill_count = shadow_fill[LIMIT_W-1:0];
        return res;
    endfunction

    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic add_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] word);
        t_stim_row row;
        row        = '{default: '0};
        row.op     = op;
        row.word   = word;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(logic [OP_W-1:0] op, logic [DATA_W-1:0] word,
                               logic [DATA_W-1:0] pop_value, logic overflow,
                               logic [LIMIT_W-1:0] fill_count);
        t_stim_row row;
        row                 = '{default: '0};
        row.typed           = 1'b1;
        row.op              = op;
        row.word            = word;
        row.want.pop_value  = pop_value;
        row.want.overflow   = overflow;
        row.want.fill_count = fill_count;
        directed_rows.push_back(row);
    endtask

    task automatic add_limit(logic [LIMIT_W-1:0] limit);
        t_stim_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.word   = DATA_W'(limit);
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] word, bit typed,
                             t_stack_result want);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            op_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_typed          = typed;
        cur_want           = want;
        op_bus.valid      <= 1'b1;
        op_bus.op         <= op;
        op_bus.push_value <= word;
        do @(posedge clk); while (!op_bus.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        op_bus.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] limit);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we       <= 1'b0;
        shadow_limit  = limit;
    endtask

    // result checking and prediction
    always @(posedge clk) begin
        t_stack_result got;
        t_stack_result want;
        t_stack_result predicted;
        if (rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                got.pop_value  = res_bus.pop_value;
                got.overflow   = res_bus.overflow;
                got.fill_count = res_bus.fill_count;
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat pop_value %h overflow %b fill %0d",
                                            got.pop_value, got.overflow, got.fill_count));
                end else begin
                    want = pending_results.pop_front();
                    if (got.pop_value !== want.pop_value)
                        note_mismatch($sformatf("pop_value exp %h got %h",
                                                want.pop_value, got.pop_value));
                    if (got.overflow !== want.overflow)
                        note_mismatch($sformatf("overflow exp %b got %b",
                                                want.overflow, got.overflow));
                    if (got.fill_count !== want.fill_count)
                        note_mismatch($sformatf("fill_count exp %0d got %0d",
                                                want.fill_count, got.fill_count));
                end
            end
            if (op_bus.valid && op_bus.ready) begin
                predicted = apply_stack_op(op_bus.op, op_bus.push_value);
                pending_results.push_back(cur_typed ? cur_want : predicted);
            end
        end
    end

    // result sink with random stalls
    initial begin
        int stall;
        res_bus.ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = draw_gap(recv_burst);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge clk); while (!res_bus.valid);
            @(negedge clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int                 p;
        int                 k;
        int unsigned        r;
        logic [OP_W-1:0]    op;
        logic [DATA_W-1:0]  word;
        logic [LIMIT_W-1:0] limit;
        op_bus.valid      = 1'b0;
        op_bus.op         = OP_PUSH;
        op_bus.push_value = '0;
        cur_typed         = 1'b0;
        cur_want          = '0;

        // empty stack after reset
        add_checked(OP_POP,  32'h0000_0000, 32'h0, 1'b0, 9'd0);
        add_checked(OP_SWAP, 32'hFFFF_FFFF, 32'h0, 1'b0, 9'd0);
        add_checked(OP_NOP,  32'hFFFF_FFFF, 32'h0, 1'b0, 9'd0);
        add_checked(OP_PUSH, 32'hFFFF_FFFF, 32'h0, 1'b0, 9'd1);
        add_checked(OP_SWAP, 32'h0000_0000, 32'h0, 1'b0, 9'd1);
        add_op(OP_PUSH, 32'h0000_0000);
        add_op(OP_SWAP, 32'h1234_5678);
        add_checked(OP_POP,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 9'd1);
        add_checked(OP_POP,  32'h0000_0000, 32'h0, 1'b0, 9'd0);
        // limit of one
        add_limit(9'd1);
        add_op(OP_PUSH, 32'hA5A5_A5A5);
        add_checked(OP_PUSH, 32'h5A5A_5A5A, 32'h0, 1'b1, 9'd1);
        add_checked(OP_NOP,  32'h0000_0000, 32'h0, 1'b0, 9'd1);
        // limit of zero with a word still held
        add_limit(9'd0);
        add_checked(OP_PUSH, 32'h1234_5678, 32'h0, 1'b1, 9'd1);
        add_checked(OP_POP,  32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 9'd0);
        add_checked(OP_PUSH, 32'h0000_0001, 32'h0, 1'b1, 9'd0);
        // limit above the store size
        add_limit(9'd511);
        add_op(OP_PUSH, 32'h7FFF_FFFF);
        add_op(OP_PUSH, 32'h8000_0000);
        // limit lowered below the fill
        add_limit(9'd1);
        add_checked(OP_PUSH, 32'hDEAD_BEEF, 32'h0, 1'b1, 9'd2);
        add_op(OP_SWAP, 32'h0000_0000);
        add_checked(OP_POP,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 9'd1);
        add_checked(OP_POP,  32'h0000_0000, 32'h8000_0000, 1'b0, 9'd0);
        add_op(OP_NOP, 32'h5555_AAAA);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_limit(directed_rows[i].word[LIMIT_W-1:0]);
            end else begin
                send_beat(directed_rows[i].op, directed_rows[i].word,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            limit = (phase_limit[p] < 0) ? LIMIT_W'($urandom_range(1, 256))
                                         : LIMIT_W'(phase_limit[p]);
            write_limit(limit);
            for (k = 0; k < phase_beats[p]; k++) begin
                r = $urandom_range(0, 99);
                if (r < phase_push[p])
                    op = OP_PUSH;
                else if (r < phase_push[p] + 12)
                    op = OP_SWAP;
                else if (r >= 97)
                    op = OP_NOP;
                else
                    op = OP_POP;
                case ($urandom_range(0, 9))
                    0: word = '0;
                    1: word = '1;
                    default: word = $urandom;
                endcase
                send_beat(op, word, 1'b0, '0);
                // hold off until the result side has caught up
                if ((p == 0 && k == 200) || $urandom_range(0, 299) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/bsws_pkg.sv
design/bsws_if.sv
design/bsws_mem.sv
design/bsws_ctrl.sv
design/bsws_obuf.sv
design/bounded_stack_with_swap.sv
verif/bounded_stack_with_swap_test.sv
